// ===== rtl/mtvb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtvb_pkg
// Item layouts, kind and op codes, and register indexes for the morph target
// vertex blender.
// ----------------------------------------------------------------------------
package mtvb_pkg;

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_BASE  = 2'd2;
  localparam logic [1:0] KIND_APPLY = 2'd3;

  // configuration registers
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_RATE    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELATIVE_MODE = 1'b1;

  // blend weight: Q1.15, one is 32768
  localparam logic [15:0] RATE_ONE   = 16'h8000;
  localparam int          RATE_SHIFT = 15;

  // classified jobs in the front-to-back queue
  localparam logic [2:0] OP_VWRITE    = 3'd0;
  localparam logic [2:0] OP_VREAD     = 3'd1;
  localparam logic [2:0] OP_BLOAD     = 3'd2;
  localparam logic [2:0] OP_APPLY_ABS = 3'd3;
  localparam logic [2:0] OP_APPLY_REL = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        vertex_index;
    logic [9:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        read_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         op;
    logic               vertex_ok;
    logic [11:0]        vertex_index;
    logic [9:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } job_t;

endpackage

// ===== rtl/mtvb_front.sv =====
// ----------------------------------------------------------------------------
// mtvb_front
// Accepts input items, decodes kind and range checks into a job, drops items
// that have no effect, and holds jobs in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mtvb_front #(
  parameter int VERTEX_COUNT = 4096,
  parameter int BASE_SLOTS   = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtvb_pkg::in_item_t in_item,
  input  logic              relative_mode,
  output logic              job_valid,
  output mtvb_pkg::job_t    job,
  input  logic              job_pop
);

  localparam int QDEPTH = 2;

  mtvb_pkg::job_t q [QDEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  mtvb_pkg::job_t cls;
  logic           keep;
  logic           vtx_ok;
  logic           slot_ok;
  logic           push;

  always_comb begin
    vtx_ok  = {20'd0, in_item.vertex_index} < 32'(VERTEX_COUNT);
    slot_ok = {22'd0, in_item.slot} < 32'(BASE_SLOTS);
    cls.vertex_ok    = vtx_ok;
    cls.vertex_index = in_item.vertex_index;
    cls.slot         = in_item.slot;
    cls.pos_x        = in_item.pos_x;
    cls.pos_y        = in_item.pos_y;
    cls.pos_z        = in_item.pos_z;
    case (in_item.kind)
      mtvb_pkg::KIND_WRITE: begin
        cls.op = mtvb_pkg::OP_VWRITE;
        keep   = vtx_ok;
      end
      mtvb_pkg::KIND_READ: begin
        cls.op = mtvb_pkg::OP_VREAD;
        keep   = 1'b1;
      end
      mtvb_pkg::KIND_BASE: begin
        cls.op = mtvb_pkg::OP_BLOAD;
        keep   = slot_ok;
      end
      mtvb_pkg::KIND_APPLY: begin
        // target range of a relative entry is known only after the base read
        if (relative_mode) begin
          cls.op = mtvb_pkg::OP_APPLY_REL;
          keep   = slot_ok;
        end else begin
          cls.op = mtvb_pkg::OP_APPLY_ABS;
          keep   = vtx_ok;
        end
      end
      default: begin
        cls.op = mtvb_pkg::OP_VREAD;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_ready  = !rst && (count != 2'(QDEPTH));
  assign push      = in_valid && in_ready && keep;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, job_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mtvb_back.sv =====
// ----------------------------------------------------------------------------
// mtvb_back
// Sequencer that carries out jobs against the vertex memory and the base
// table: direct writes, reads into the output register, and the blend
// read-modify-write (optional base lookup, difference, multiply, write back).
// ----------------------------------------------------------------------------
module mtvb_back #(
  parameter int VERTEX_COUNT = 4096,
  parameter int BASE_SLOTS   = 1024,
  parameter int COORD_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  mtvb_pkg::job_t      job,
  output logic                job_pop,
  input  logic [15:0]         blend_rate,
  output logic                out_valid,
  input  logic                out_ready,
  output mtvb_pkg::out_item_t out_item
);

  localparam int VA = $clog2(VERTEX_COUNT);
  localparam int BA = $clog2(BASE_SLOTS);
  localparam int CB = COORD_BITS;
  localparam int DB = COORD_BITS + 1;
  localparam int PB = COORD_BITS + 18;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_VTX  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  // memories
  logic signed [CB-1:0] vmem_x [VERTEX_COUNT];
  logic signed [CB-1:0] vmem_y [VERTEX_COUNT];
  logic signed [CB-1:0] vmem_z [VERTEX_COUNT];
  logic [11:0]          bmem_t [BASE_SLOTS];
  logic signed [CB-1:0] bmem_x [BASE_SLOTS];
  logic signed [CB-1:0] bmem_y [BASE_SLOTS];
  logic signed [CB-1:0] bmem_z [BASE_SLOTS];

  logic                 vwe;
  logic                 vre;
  logic [VA-1:0]        vwaddr;
  logic [VA-1:0]        vraddr;
  logic signed [CB-1:0] vw_x, vw_y, vw_z;
  logic signed [CB-1:0] vrd_x, vrd_y, vrd_z;

  logic                 bwe;
  logic                 bre;
  logic [BA-1:0]        baddr;
  logic [11:0]          brd_t;
  logic signed [CB-1:0] brd_x, brd_y, brd_z;

  // sequencer registers
  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [2:0]           cur_op;
  logic [VA-1:0]        tgt;
  logic [11:0]          rd_index;
  logic                 rd_ok;
  logic signed [CB-1:0] goal_x, goal_y, goal_z;
  logic signed [CB-1:0] cur_x, cur_y, cur_z;
  logic signed [DB-1:0] diff_x, diff_y, diff_z;
  logic signed [PB-1:0] prod_x, prod_y, prod_z;

  logic [15:0]          rate_eff;
  logic signed [16:0]   rate_s;
  logic signed [DB-1:0] sum_x, sum_y, sum_z;
  logic signed [CB-1:0] sat_x, sat_y, sat_z;
  logic signed [PB-1:0] sh_x, sh_y, sh_z;
  logic                 btgt_ok;
  logic                 out_load;

  function automatic logic signed [CB-1:0] sat_fn(input logic signed [DB-1:0] s);
    logic signed [CB-1:0] r;
    if (s[DB-1] != s[DB-2]) begin
      r = s[DB-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      r = s[CB-1:0];
    end
    return r;
  endfunction

  always_comb begin
    rate_eff = (blend_rate > mtvb_pkg::RATE_ONE) ? mtvb_pkg::RATE_ONE : blend_rate;
    rate_s   = $signed({1'b0, rate_eff});
    sum_x    = DB'(goal_x) + DB'(brd_x);
    sum_y    = DB'(goal_y) + DB'(brd_y);
    sum_z    = DB'(goal_z) + DB'(brd_z);
    sat_x    = sat_fn(sum_x);
    sat_y    = sat_fn(sum_y);
    sat_z    = sat_fn(sum_z);
    sh_x     = prod_x >>> mtvb_pkg::RATE_SHIFT;
    sh_y     = prod_y >>> mtvb_pkg::RATE_SHIFT;
    sh_z     = prod_z >>> mtvb_pkg::RATE_SHIFT;
    btgt_ok  = {20'd0, brd_t} < 32'(VERTEX_COUNT);
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    vwe        = 1'b0;
    vre        = 1'b0;
    vwaddr     = VA'(job.vertex_index);
    vraddr     = VA'(job.vertex_index);
    vw_x       = job.pos_x[CB-1:0];
    vw_y       = job.pos_y[CB-1:0];
    vw_z       = job.pos_z[CB-1:0];
    bwe        = 1'b0;
    bre        = 1'b0;
    baddr      = BA'(job.slot);
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          case (job.op)
            mtvb_pkg::OP_VWRITE: vwe = 1'b1;
            mtvb_pkg::OP_BLOAD:  bwe = 1'b1;
            mtvb_pkg::OP_VREAD, mtvb_pkg::OP_APPLY_ABS: begin
              vre        = 1'b1;
              state_next = S_VTX;
            end
            mtvb_pkg::OP_APPLY_REL: begin
              bre        = 1'b1;
              state_next = S_BASE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_BASE: begin
        vraddr = VA'(brd_t);
        if (btgt_ok) begin
          vre        = 1'b1;
          state_next = S_VTX;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_VTX: begin
        if (cur_op == mtvb_pkg::OP_VREAD) begin
          if (!out_valid || out_ready) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_WR;
      S_WR: begin
        vwe        = 1'b1;
        vwaddr     = tgt;
        vw_x       = cur_x + sh_x[CB-1:0];
        vw_y       = cur_y + sh_y[CB-1:0];
        vw_z       = cur_z + sh_z[CB-1:0];
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem_x[vwaddr] <= vw_x;
      vmem_y[vwaddr] <= vw_y;
      vmem_z[vwaddr] <= vw_z;
    end
    if (vre) begin
      vrd_x <= vmem_x[vraddr];
      vrd_y <= vmem_y[vraddr];
      vrd_z <= vmem_z[vraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem_t[baddr] <= job.vertex_index;
      bmem_x[baddr] <= job.pos_x[CB-1:0];
      bmem_y[baddr] <= job.pos_y[CB-1:0];
      bmem_z[baddr] <= job.pos_z[CB-1:0];
    end
    if (bre) begin
      brd_t <= bmem_t[baddr];
      brd_x <= bmem_x[baddr];
      brd_y <= bmem_y[baddr];
      brd_z <= bmem_z[baddr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      cur_op   <= job.op;
      tgt      <= VA'(job.vertex_index);
      rd_index <= job.vertex_index;
      rd_ok    <= job.vertex_ok;
      // in relative mode these hold the offset until the base arrives
      goal_x   <= job.pos_x[CB-1:0];
      goal_y   <= job.pos_y[CB-1:0];
      goal_z   <= job.pos_z[CB-1:0];
    end
    if (state == S_BASE) begin
      tgt    <= VA'(brd_t);
      goal_x <= sat_x;
      goal_y <= sat_y;
      goal_z <= sat_z;
    end
    if (state == S_VTX) begin
      cur_x  <= vrd_x;
      cur_y  <= vrd_y;
      cur_z  <= vrd_z;
      diff_x <= DB'(goal_x) - DB'(vrd_x);
      diff_y <= DB'(goal_y) - DB'(vrd_y);
      diff_z <= DB'(goal_z) - DB'(vrd_z);
    end
    if (state == S_MUL) begin
      prod_x <= diff_x * rate_s;
      prod_y <= diff_y * rate_s;
      prod_z <= diff_z * rate_s;
    end
    if (out_load) begin
      out_item.read_index <= rd_index;
      out_item.out_x      <= rd_ok ? 32'(vrd_x) : 32'sd0;
      out_item.out_y      <= rd_ok ? 32'(vrd_y) : 32'sd0;
      out_item.out_z      <= rd_ok ? 32'(vrd_z) : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/morph_target_vertex_blend_top.sv =====
// ----------------------------------------------------------------------------
// morph_target_vertex_blend_top
// Morph target vertex blender: vertex position memory plus base-face table,
// with direct vertex writes and reads and blended morph entry application.
//
//   Channel | Dir | Handshake            | Payload
//   --------+-----+----------------------+---------------------------------
//   in      | in  | in_valid / in_ready  | in_item  (kind, index, slot, xyz)
//   out     | out | out_valid/ out_ready | out_item (read_index, xyz)
//   cfg     | in  | cfg_we               | cfg_addr, cfg_wdata
//
// The back sequencer takes one job at a time. A vertex write or base load ends
// in S_IDLE; a read passes S_VTX (held while the output register is full); a
// morph entry is a serialized read-modify-write on the vertex memory through
// S_VTX, S_MUL, S_WR, after S_BASE if relative (ending there if out of range).
// Dropped items never reach the back end. Reset clears control and config
// only; memories hold garbage until written. A two-entry job queue lets
// input accepts run ahead of the back end; a stalled output blocks the back
// end only while a read waits on it.
// ----------------------------------------------------------------------------
module morph_target_vertex_blend_top #(
  parameter int VERTEX_COUNT = 4096,
  parameter int BASE_SLOTS   = 1024,
  parameter int COORD_BITS   = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  mtvb_pkg::in_item_t                      in_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output mtvb_pkg::out_item_t                     out_item,
  input  logic                                    cfg_we,
  input  logic [mtvb_pkg::CFG_INDEX_BITS-1:0]     cfg_addr,
  input  logic [mtvb_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  logic [15:0]    blend_rate;
  logic           relative_mode;
  logic           job_valid;
  logic           job_pop;
  mtvb_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_rate    <= mtvb_pkg::RATE_ONE;
      relative_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mtvb_pkg::REG_BLEND_RATE:    blend_rate    <= cfg_wdata;
        mtvb_pkg::REG_RELATIVE_MODE: relative_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mtvb_front #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .BASE_SLOTS   (BASE_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .relative_mode (relative_mode),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop)
  );

  mtvb_back #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .BASE_SLOTS   (BASE_SLOTS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .blend_rate (blend_rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== tb/tb_morph_target_vertex_blend_top.sv =====
// ----------------------------------------------------------------------------
// tb_morph_target_vertex_blend_top
// Self-checking bench for the morph target vertex blender. A mirror of the
// vertex memory and base table predicts every read; directed items cover the
// coordinate extremes, rate clamping and goal saturation, then random phases
// sweep the blend rate and both morph modes with random stalls on each side.
// ----------------------------------------------------------------------------
module tb_morph_target_vertex_blend_top;
  import mtvb_pkg::*;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam int DRAIN_CYCLES = 32;

  // mirror of the vertex memory, base table and registers
  class vertex_store_model;
    logic signed [31:0] vx [4096];
    logic signed [31:0] vy [4096];
    logic signed [31:0] vz [4096];
    logic [11:0]        base_vtx [1024];
    logic signed [31:0] bx [1024];
    logic signed [31:0] by [1024];
    logic signed [31:0] bz [1024];
    logic [15:0]        rate = RATE_ONE;
    bit                 relative = 1'b0;
    out_item_t          pending_reads [$];
    int                 errors = 0;

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_BLEND_RATE) rate = val;
      else if (idx == REG_RELATIVE_MODE) relative = val[0];
    endfunction

    // cur + floor((goal - cur) * rate / 2^15), rate clamped to one
    function logic signed [31:0] lerp(logic signed [31:0] cur, logic signed [31:0] goal);
      longint r;
      longint p;
      r = (rate > RATE_ONE) ? longint'(RATE_ONE) : longint'(rate);
      p = (longint'(goal) - longint'(cur)) * r;
      return cur + 32'(p >>> RATE_SHIFT);
    endfunction

    function logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(POS_MAX)) return POS_MAX;
      if (s < longint'(POS_MIN)) return POS_MIN;
      return 32'(s);
    endfunction

    function void take_item(in_item_t it);
      logic [11:0]        t;
      logic signed [31:0] gx, gy, gz;
      out_item_t          rd;
      case (it.kind)
        KIND_WRITE: begin
          vx[it.vertex_index] = it.pos_x;
          vy[it.vertex_index] = it.pos_y;
          vz[it.vertex_index] = it.pos_z;
        end
        KIND_READ: begin
          rd.read_index = it.vertex_index;
          rd.out_x = vx[it.vertex_index];
          rd.out_y = vy[it.vertex_index];
          rd.out_z = vz[it.vertex_index];
          pending_reads.push_back(rd);
        end
        KIND_BASE: begin
          base_vtx[it.slot] = it.vertex_index;
          bx[it.slot] = it.pos_x;
          by[it.slot] = it.pos_y;
          bz[it.slot] = it.pos_z;
        end
        default: begin
          t = it.vertex_index;
          gx = it.pos_x;
          gy = it.pos_y;
          gz = it.pos_z;
          if (relative) begin
            t = base_vtx[it.slot];
            gx = sat_sum(it.pos_x, bx[it.slot]);
            gy = sat_sum(it.pos_y, by[it.slot]);
            gz = sat_sum(it.pos_z, bz[it.slot]);
          end
          vx[t] = lerp(vx[t], gx);
          vy[t] = lerp(vy[t], gy);
          vz[t] = lerp(vz[t], gz);
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_read(out_item_t got);
      out_item_t want;
      if (pending_reads.size() == 0) begin
        report("unexpected result, read_index", 32'(got.read_index), 32'h0);
        return;
      end
      want = pending_reads.pop_front();
      if (got.read_index != want.read_index)
        report("read_index", 32'(got.read_index), 32'(want.read_index));
      if (got.out_x != want.out_x) report("out_x", got.out_x, want.out_x);
      if (got.out_y != want.out_y) report("out_y", got.out_y, want.out_y);
      if (got.out_z != want.out_z) report("out_z", got.out_z, want.out_z);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  vertex_store_model book = new();
  bit gaps_on = 1'b1;

  // stimulus-side record of what has been written
  bit          vtx_seen [4096];
  logic [11:0] vtx_list [$];
  bit          slot_seen [1024];
  logic [9:0]  slot_list [$];
  logic [11:0] slot_vtx [1024];

  morph_target_vertex_blend_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_read(out_item);
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 21);
  end

  initial begin
    #2000000;
    $display("morph_target_vertex_blend_top verification failed");
    $finish;
  end

  task automatic push_item(in_item_t it);
    if (gaps_on && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 21);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    book.take_item(it);
    if (it.kind == KIND_WRITE && !vtx_seen[it.vertex_index]) begin
      vtx_seen[it.vertex_index] = 1'b1;
      vtx_list.push_back(it.vertex_index);
    end
    if (it.kind == KIND_BASE) begin
      slot_vtx[it.slot] = it.vertex_index;
      if (!slot_seen[it.slot]) begin
        slot_seen[it.slot] = 1'b1;
        slot_list.push_back(it.slot);
      end
    end
  endtask

  task automatic put(logic [1:0] k, logic [11:0] vi, logic [9:0] sl,
                     logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    in_item_t it;
    it = '{kind: k, vertex_index: vi, slot: sl, pos_x: x, pos_y: y, pos_z: z};
    push_item(it);
  endtask

  // wait for every read to come back, then let trailing writes finish
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] rate, bit rel);
    settle();
    write_reg(REG_BLEND_RATE, rate);
    write_reg(REG_RELATIVE_MODE, {15'd0, rel});
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return $signed(32'($urandom_range(0, 32'h000F_FFFF))) - 32'sh0008_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [11:0] rand_vertex();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 12'($urandom_range(0, 15));
    if (r < 70) return 12'($urandom_range(4080, 4095));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [9:0] rand_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 10'($urandom_range(0, 7));
    if (r < 70) return 10'($urandom_range(1016, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [11:0] known_vertex();
    return vtx_list[$urandom_range(0, vtx_list.size() - 1)];
  endfunction

  // reads and morphs only touch entries already written
  function automatic in_item_t random_item();
    in_item_t   it;
    int         r;
    logic [9:0] s;
    r = $urandom_range(0, 99);
    it.kind = KIND_WRITE;
    it.vertex_index = rand_vertex();
    it.slot = 10'($urandom());
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    if (vtx_list.size() == 0 || r < 25) return it;
    if (r < 50) begin
      it.kind = KIND_READ;
      it.vertex_index = known_vertex();
    end else if (r < 62) begin
      it.kind = KIND_BASE;
      it.slot = rand_slot();
      it.vertex_index = ($urandom_range(0, 99) < 85) ? known_vertex()
                                                    : 12'($urandom_range(0, 4095));
    end else if (!book.relative) begin
      it.kind = KIND_APPLY;
      it.vertex_index = known_vertex();
    end else begin
      repeat (4) begin
        if (slot_list.size() != 0 && it.kind != KIND_APPLY) begin
          s = slot_list[$urandom_range(0, slot_list.size() - 1)];
          if (vtx_seen[slot_vtx[s]]) begin
            it.kind = KIND_APPLY;
            it.slot = s;
            it.vertex_index = 12'($urandom());
          end
        end
      end
    end
    return it;
  endfunction

  initial begin
    logic [15:0] phase_rate [8];
    phase_rate = '{16'd1, 16'd32767, 16'd0, 16'hFFFF, RATE_ONE,
                   16'($urandom()), 16'd16384, 16'($urandom_range(0, 32768))};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes, reads back, base entries, exact overwrite at rate one
    put(KIND_WRITE, 12'd0,     10'h3FF, POS_MAX, POS_MIN, 32'sd0);
    put(KIND_WRITE, 12'hFFF,   10'h155, POS_MIN, POS_MAX, -32'sd1);
    put(KIND_WRITE, 12'hAAA,   10'h000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1);
    put(KIND_READ,  12'd0,     10'h2AA, 32'sd0, -32'sd1, POS_MAX);
    put(KIND_READ,  12'hFFF,   10'h155, POS_MIN, 32'sd0, 32'sd0);
    put(KIND_READ,  12'hAAA,   10'h3FF, -32'sd1, -32'sd1, -32'sd1);
    put(KIND_BASE,  12'hFFF,   10'd0,   POS_MAX, POS_MIN, 32'sh4000_0000);
    put(KIND_BASE,  12'd0,     10'h3FF, -32'sd1, 32'sd1, 32'sd0);
    put(KIND_BASE,  12'hAAA,   10'h2AA, 32'sh1234_5678, -32'sh1234_5678, POS_MIN);
    put(KIND_APPLY, 12'd0,     10'h3FF, 32'sd1, 32'sd2, 32'sd3);
    put(KIND_READ,  12'd0,     10'd0,   32'sd0, 32'sd0, 32'sd0);
    put(KIND_APPLY, 12'hFFF,   10'h155, POS_MAX, POS_MIN, 32'sd0);
    put(KIND_READ,  12'hFFF,   10'd0,   32'sd0, 32'sd0, 32'sd0);
    // rate above one behaves as one
    configure(16'hFFFF, 1'b0);
    put(KIND_APPLY, 12'hAAA,   10'h2AA, -32'sd5, 32'sd7, POS_MIN);
    put(KIND_READ,  12'hAAA,   10'd0,   32'sd0, 32'sd0, 32'sd0);
    // fractional rate, negative steps round toward minus infinity
    configure(16'd16385, 1'b0);
    put(KIND_APPLY, 12'd0,     10'd0,   POS_MIN, POS_MAX, -32'sd7);
    put(KIND_READ,  12'd0,     10'd0,   32'sd0, 32'sd0, 32'sd0);
    // relative goals, saturating in both directions
    configure(RATE_ONE, 1'b1);
    put(KIND_APPLY, 12'h123,   10'd0,   32'sd1, -32'sd1, POS_MAX);
    put(KIND_READ,  12'hFFF,   10'd0,   32'sd0, 32'sd0, 32'sd0);
    put(KIND_APPLY, 12'hFFF,   10'h3FF, 32'sd5, 32'sd5, 32'sd5);
    put(KIND_READ,  12'd0,     10'd0,   32'sd0, 32'sd0, 32'sd0);
    // zero rate leaves the vertex alone
    configure(16'd0, 1'b1);
    put(KIND_APPLY, 12'd0,     10'h2AA, POS_MAX, POS_MIN, -32'sd1);
    put(KIND_READ,  12'hAAA,   10'd0,   32'sd0, 32'sd0, 32'sd0);

    for (int p = 0; p < 8; p++) begin
      configure(phase_rate[p], p[0]);
      gaps_on = (p != 3);
      repeat (50) push_item(random_item());
    end

    settle();
    if (book.errors == 0) begin
      $display("morph_target_vertex_blend_top verification clean");
    end else begin
      $display("morph_target_vertex_blend_top verification failed");
    end
    $finish;
  end

endmodule
